// ----- src/tsi2c_pkg.sv -----
package tsi2c_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_POINTER = 2'd1,
    PH_MSB     = 2'd2,
    PH_LSB     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BUS_BYTE  = 2'd0,
    CMD_TEMP_NORM = 2'd1,
    CMD_TEMP_EXT  = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd72;
  localparam int unsigned EXT_MODE_BIT  = 4;
  localparam int unsigned RATE_LO_BIT   = 6;

  typedef struct packed {
    logic       response_valid;
    logic [7:0] response_msb;
    logic [7:0] response_lsb;
    logic       extended_mode;
    logic [1:0] rate_code;
  } result_t;

endpackage

// ----- src/temp_sensor_i2c_register_slave.sv -----
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// input     | in_valid/in_ready  | in_command, in_bus_byte, in_end_of_transfer,
//           |                    | in_temperature_code
// result    | out_valid/out_ready| out_response_valid, out_response_msb,
//           |                    | out_response_lsb, out_extended_mode, out_rate_code
// config    | cfg_we             | cfg_wdata (device address)
//
// one request per cycle while in_ready is high; each accepted request yields one result;
// state and register file update at the accepting edge, result lands in an output
// register backed by a one-entry skid stage, so in_ready drops only when both are full
// rst_n is synchronous: phase idle, pointer zero, register file all zero, address 72
module temp_sensor_i2c_register_slave
  import tsi2c_pkg::*;
#(
  parameter int unsigned REG_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_bus_byte,
  input  logic        in_end_of_transfer,
  input  logic signed [12:0] in_temperature_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_response_valid,
  output logic [7:0]  out_response_msb,
  output logic [7:0]  out_response_lsb,
  output logic        out_extended_mode,
  output logic [1:0]  out_rate_code,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0]  REG_COUNT_W = 9'(REG_COUNT);

  logic [6:0]  device_address_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  pointer_r, pointer_nxt;
  logic [15:0] store_r   [REG_COUNT];
  logic [15:0] store_nxt [REG_COUNT];

  result_t     main_r, main_nxt, skid_r, skid_nxt, res_new;
  logic        main_valid_r, main_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic        push, pop;
  logic [7:0]  wr_addr, rd_addr;
  logic        ptr_in_range;
  logic [IDX_W-1:0] ptr_idx;
  logic        is_bus, wr_msb, wr_lsb, rd_hit;
  logic [15:0] rd_word, cfg_word;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = main_valid_r && out_ready;

  assign wr_addr      = {device_address_r, 1'b0};
  assign rd_addr      = {device_address_r, 1'b1};
  assign ptr_in_range = {1'b0, pointer_r} < REG_COUNT_W;
  assign ptr_idx      = pointer_r[IDX_W-1:0];
  assign is_bus       = (cmd_t'(in_command) == CMD_BUS_BYTE);
  assign wr_msb       = is_bus && (phase_r == PH_MSB) && ptr_in_range;
  assign wr_lsb       = is_bus && (phase_r == PH_LSB) && ptr_in_range;
  assign rd_hit       = is_bus && (phase_r == PH_IDLE) && (in_bus_byte != wr_addr)
                        && (in_bus_byte == rd_addr);
  assign rd_word      = ptr_in_range ? store_r[ptr_idx] : 16'h0000;

  // next state of the bus phase and pointer
  always_comb begin
    phase_nxt   = phase_r;
    pointer_nxt = pointer_r;
    if (is_bus) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_bus_byte == wr_addr) phase_nxt = PH_POINTER;
        end
        PH_POINTER: begin
          pointer_nxt = in_bus_byte;
          phase_nxt   = PH_MSB;
        end
        PH_MSB:  phase_nxt = PH_LSB;
        PH_LSB:  phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
      if (in_end_of_transfer) phase_nxt = PH_IDLE;
    end
  end

  // register file writes from the bus and from the temperature commands
  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      store_nxt[i] = store_r[i];
      if (wr_msb && ptr_idx == IDX_W'(i)) store_nxt[i][15:8] = in_bus_byte;
      if (wr_lsb && ptr_idx == IDX_W'(i)) store_nxt[i][7:0]  = in_bus_byte;
    end
    case (cmd_t'(in_command))
      CMD_TEMP_NORM: store_nxt[0] = {in_temperature_code[11:0], 4'h0};
      CMD_TEMP_EXT:  store_nxt[0] = {in_temperature_code[12:0], 3'b001};
      default: ;
    endcase
  end

  generate
    if (REG_COUNT > 1) begin : g_cfg
      assign cfg_word = store_nxt[1];
    end else begin : g_no_cfg
      assign cfg_word = 16'h0000;
    end
  endgenerate

  always_comb begin
    res_new.response_valid = rd_hit;
    res_new.response_msb   = rd_hit ? rd_word[15:8] : 8'h00;
    res_new.response_lsb   = rd_hit ? rd_word[7:0]  : 8'h00;
    res_new.extended_mode  = cfg_word[EXT_MODE_BIT];
    res_new.rate_code      = cfg_word[RATE_LO_BIT +: 2];
  end

  // output register with one skid entry
  always_comb begin
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = push;
        skid_nxt       = res_new;
      end else begin
        main_valid_nxt = push;
        main_nxt       = res_new;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= DEV_ADDR_RESET;
      phase_r          <= PH_IDLE;
      pointer_r        <= 8'h00;
      main_valid_r     <= 1'b0;
      skid_valid_r     <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) store_r[i] <= 16'h0000;
    end else begin
      if (cfg_we) device_address_r <= cfg_wdata;
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (push) begin
        phase_r   <= phase_nxt;
        pointer_r <= pointer_nxt;
        for (int i = 0; i < REG_COUNT; i++) store_r[i] <= store_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = main_valid_r;
  assign out_response_valid = main_r.response_valid;
  assign out_response_msb   = main_r.response_msb;
  assign out_response_lsb   = main_r.response_lsb;
  assign out_extended_mode  = main_r.extended_mode;
  assign out_rate_code      = main_r.rate_code;

endmodule
